// ===== sv/assert_macros.svh =====
// assertion helpers used by the core rtl file
// both expect signals named clock and reset in the calling module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// antecedent at one edge implies consequent at the next
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/pctx_pkg.sv =====
// ----------------------------------------------------------------------------
// pctx_pkg
// types, constants and elaboration-time tables of the pixel contrast transform
// ----------------------------------------------------------------------------
`default_nettype none

package pctx_pkg;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } rsp_type;

   typedef enum logic [1:0] {
      MODE_LINEAR = 2'd0,
      MODE_LOG    = 2'd1,
      MODE_POWER  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      CSR_MODE  = 2'd0,
      CSR_GAIN  = 2'd1,
      CSR_GAMMA = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] gain;
      logic [11:0] gamma;
   } cfg_type;

   localparam logic [31:0] LN2_Q32   = 32'd2977044472;
   localparam int          EXP_TERMS = 13;
   localparam int          DIV_SHIFT = 34;
   // table, linear/log, exp prologue, two stages per taylor term, product, round, output
   localparam int          LANE_DEPTH = 3 + 2 * EXP_TERMS + 3;

   typedef logic [22:0] tab_type [256];
   typedef logic [34:0] magic_type [EXP_TERMS];

   // ceil(2^34 / k) for k = 1..13, exact floor division of values below 2^30
   localparam magic_type DIV_MAGIC = '{
      35'd17179869184, 35'd8589934592, 35'd5726623062, 35'd4294967296,
      35'd3435973837,  35'd2863311531, 35'd2454267027, 35'd2147483648,
      35'd1908874354,  35'd1717986919, 35'd1561806290, 35'd1431655766,
      35'd1321528399
   };

   // log2 in q.20, integer part from the leading one, fraction by squaring
   function automatic logic [23:0] log2_q20(input logic [8:0] x);
      logic [3:0]  e;
      logic [19:0] frac;
      logic [63:0] m;
      e    = 4'd0;
      frac = 20'd0;
      for (int i = 0; i < 8; i++) begin
         if ((x >> (e + 4'd1)) != 9'd0) begin
            e = e + 4'd1;
         end
      end
      m = 64'(x) << (6'd30 - 6'(e));
      for (int i = 0; i < 20; i++) begin
         m    = (m * m) >> 30;
         frac = {frac[18:0], 1'b0};
         if (m >= 64'h8000_0000) begin
            m       = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return {e, frac};
   endfunction

   function automatic tab_type build_log2_tab();
      tab_type tab;
      for (int v = 0; v < 256; v++) begin
         tab[v] = 23'(log2_q20(9'(v)));
      end
      return tab;
   endfunction

   // ln(v + 1) in q.20
   function automatic tab_type build_ln_tab();
      tab_type     tab;
      logic [63:0] acc;
      for (int v = 0; v < 256; v++) begin
         acc    = 64'(log2_q20(9'(v + 1))) * 64'(LN2_Q32) + 64'h8000_0000;
         tab[v] = 23'(acc >> 32);
      end
      return tab;
   endfunction

   localparam tab_type LOG2_TAB = build_log2_tab();
   localparam tab_type LN_TAB   = build_ln_tab();

endpackage

`default_nettype wire

// ===== sv/pctx_lane.sv =====
// ----------------------------------------------------------------------------
// pctx_lane
// one color channel: linear, log and power law paths, all stages advance on adv
// ----------------------------------------------------------------------------
`default_nettype none

module pctx_lane
   import pctx_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       adv,
   input  wire cfg_type    cfg,
   input  wire logic [7:0] value,
   output logic [7:0]      result
);

   typedef struct packed {
      logic [7:0] lin_byte;
      logic [7:0] log_byte;
      logic       vzero;
      logic       big;
      logic [3:0] nsh;
   } side_type;

   logic        neg;
   logic [15:0] gmag;

   assign neg  = cfg.gain[15];
   assign gmag = neg ? 16'(-cfg.gain) : cfg.gain;

   // stage 1: table lookups
   logic [7:0]  v1_ff;
   logic [22:0] lg1_ff, ln1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         v1_ff  <= value;
         lg1_ff <= LOG2_TAB[value];
         ln1_ff <= LN_TAB[value];
      end
   end

   // stage 2: products
   logic [34:0] t2_ff;
   logic [23:0] linp2_ff;
   logic [38:0] logp2_ff;
   logic        vz2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         t2_ff    <= 35'(lg1_ff) * 35'(cfg.gamma);
         linp2_ff <= 24'(gmag) * 24'(v1_ff);
         logp2_ff <= 39'(gmag) * 39'(ln1_ff);
         vz2_ff   <= (v1_ff == 8'd0);
      end
   end

   // stage 3: linear and log finish, power fraction to natural scale
   logic [16:0] lin_r;
   logic [11:0] log_r;
   logic [7:0]  lin_byte, log_byte;
   logic [59:0] yprod;
   logic [29:0] y3_ff;
   side_type    side3_ff;

   always_comb begin
      lin_r = 17'((25'(linp2_ff) + 25'd128) >> 8);
      if (neg) begin
         lin_byte = (lin_r <= 17'd255) ? 8'(17'd255 - lin_r) : 8'd0;
      end else begin
         lin_byte = (lin_r > 17'd255) ? 8'd255 : lin_r[7:0];
      end
      log_r    = 12'((40'(logp2_ff) + 40'h800_0000) >> 28);
      log_byte = neg ? 8'd0 : ((log_r > 12'd255) ? 8'd255 : log_r[7:0]);
      yprod    = 60'(t2_ff[27:0]) * 60'(LN2_Q32);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         y3_ff             <= 30'(yprod >> 30);
         side3_ff.lin_byte <= lin_byte;
         side3_ff.log_byte <= log_byte;
         side3_ff.vzero    <= vz2_ff;
         side3_ff.big      <= |t2_ff[34:32];
         side3_ff.nsh      <= t2_ff[31:28];
      end
   end

   // exp by taylor terms, term k = floor(((term * y) >> 30) / k)
   logic [30:0] term_q [EXP_TERMS+1];
   logic [31:0] e_q    [EXP_TERMS+1];
   logic [29:0] y_q    [EXP_TERMS+1];
   side_type    side_q [EXP_TERMS+1];

   assign term_q[0] = 31'h4000_0000;
   assign e_q[0]    = 32'h4000_0000;
   assign y_q[0]    = y3_ff;
   assign side_q[0] = side3_ff;

   for (genvar k = 1; k <= EXP_TERMS; k++) begin : g_term
      logic [29:0] x_ff;
      logic [29:0] ya_ff;
      logic [31:0] ea_ff;
      side_type    sa_ff;
      logic [30:0] tb_ff;
      logic [31:0] eb_ff;
      logic [29:0] yb_ff;
      side_type    sb_ff;
      logic [60:0] mprod;
      logic [64:0] dprod;

      assign mprod = 61'(term_q[k-1]) * 61'(y_q[k-1]);
      assign dprod = 65'(x_ff) * 65'(DIV_MAGIC[k-1]);

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff  <= 30'(mprod >> 30);
            ya_ff <= y_q[k-1];
            ea_ff <= e_q[k-1];
            sa_ff <= side_q[k-1];
            tb_ff <= 31'(dprod >> DIV_SHIFT);
            eb_ff <= ea_ff + 32'(31'(dprod >> DIV_SHIFT));
            yb_ff <= ya_ff;
            sb_ff <= sa_ff;
         end
      end

      assign term_q[k] = tb_ff;
      assign e_q[k]    = eb_ff;
      assign y_q[k]    = yb_ff;
      assign side_q[k] = sb_ff;
   end

   // gain product, rounding, output select
   logic [47:0] p_ff;
   side_type    sp_ff, ss_ff;
   logic [63:0] sum_ff;
   logic [63:0] pow_r;
   logic [7:0]  pow_byte;
   logic [7:0]  out_ff;

   always_comb begin
      pow_r = sum_ff >> (6'd38 - 6'(ss_ff.nsh));
      if (ss_ff.vzero && (cfg.gamma != 12'd0)) begin
         pow_byte = 8'd0;
      end else if (ss_ff.big) begin
         pow_byte = (!neg && (cfg.gain != 16'd0)) ? 8'd255 : 8'd0;
      end else if (neg) begin
         pow_byte = 8'd0;
      end else begin
         pow_byte = (pow_r > 64'd255) ? 8'd255 : pow_r[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff   <= 48'(gmag) * 48'(e_q[EXP_TERMS]);
         sp_ff  <= side_q[EXP_TERMS];
         sum_ff <= (64'(p_ff) << sp_ff.nsh) + (64'd1 << (6'd37 - 6'(sp_ff.nsh)));
         ss_ff  <= sp_ff;
         case (cfg.mode)
            MODE_LOG:   out_ff <= ss_ff.log_byte;
            MODE_POWER: out_ff <= pow_byte;
            default:    out_ff <= ss_ff.lin_byte;
         endcase
      end
   end

   assign result = out_ff;

endmodule

`default_nettype wire

// ===== sv/pixel_contrast_point_transform_core.sv =====
// ----------------------------------------------------------------------------
// pixel_contrast_point_transform_core
// per-channel linear, log or power law intensity transform of one rgb pixel
// ----------------------------------------------------------------------------
//
//   channel   direction   ports                               moves
//   req       in          req_valid, req_stall, req_data      one pixel word
//   rsp       out         rsp_valid, rsp_stall, rsp_data      one pixel word
//   csr       in          csr_write_en, csr_index, csr_wdata  one register write
//
// one pixel word enters per clock while rsp is not stalling the pipe
// the pipe is mostly the exp series: 13 taylor terms at two stages each
// reset is synchronous, clears the valid pipe and restores the registers
// a stall on a valid rsp word freezes the whole pipe and raises req_stall the same cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_contrast_point_transform_core
   import pctx_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // pixel in
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   // pixel out
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   // register writes
   input  wire logic        csr_write_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

`include "assert_macros.svh"

   // configuration registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode  <= MODE_LINEAR;
         cfg_ff.gain  <= 16'd256;
         cfg_ff.gamma <= 12'd256;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MODE:  cfg_ff.mode  <= csr_wdata[1:0];
            CSR_GAIN:  cfg_ff.gain  <= csr_wdata;
            CSR_GAMMA: cfg_ff.gamma <= csr_wdata[11:0];
            default:   ;
         endcase
      end
   end

   // the pipe moves whenever the output word is empty or taken
   logic                  adv;
   logic [LANE_DEPTH-1:0] vld_ff;

   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[LANE_DEPTH-1];

   // valid bits travel alongside the lane data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LANE_DEPTH-2:0], req_valid};
      end
   end

   // one lane per color channel
   pctx_lane u_red (
      .clock  (clock),
      .adv    (adv),
      .cfg    (cfg_ff),
      .value  (req_data.red_in),
      .result (rsp_data.red_out)
   );

   pctx_lane u_green (
      .clock  (clock),
      .adv    (adv),
      .cfg    (cfg_ff),
      .value  (req_data.green_in),
      .result (rsp_data.green_out)
   );

   pctx_lane u_blue (
      .clock  (clock),
      .adv    (adv),
      .cfg    (cfg_ff),
      .value  (req_data.blue_in),
      .result (rsp_data.blue_out)
   );

   `ASSERT_ALWAYS(a_stall_from_output, req_stall == (rsp_valid && rsp_stall), "stall mismatch")
   `ASSERT_NEXT(a_accept_enters, req_valid && !req_stall, vld_ff[0], "accepted word lost")
   `ASSERT_NEXT(a_pipe_shift, adv, rsp_valid == $past(vld_ff[LANE_DEPTH-2]), "valid pipe slip")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the pixel contrast point transform core
// drives pixel words under random idling on both sides, writes the mode, gain
// and gamma registers between phases, and checks every result word against a
// known value or a bit-exact predictor of linear, log and power law transforms
// ----------------------------------------------------------------------------
`default_nettype none

module tb
   import pctx_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned LN2 = 64'd2977044472;
   localparam int PIPE_CYCLES = 40;
   localparam longint CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   always #5 clock = ~clock;

   pixel_contrast_point_transform_core uut (.*);

   // predictor copy of the registers
   logic [1:0]  cur_mode;
   logic [15:0] cur_gain;
   logic [11:0] cur_gamma;

   rsp_type pending_pixels[$];
   int      errors = 0;
   int      pixels_sent = 0;
   int      pixels_checked = 0;
   longint  cycles = 0;

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------
   function automatic longint unsigned log2_fix(input int unsigned x);
      int unsigned     ex;
      int unsigned     fr;
      longint unsigned m;
      ex = 0;
      fr = 0;
      while (ex < 8 && (x >> (ex + 1)) != 0) ex++;
      m = longint'(x & 9'h1ff) << (30 - ex);
      for (int i = 0; i < 20; i++) begin
         m  = (m * m) >> 30;
         fr = fr << 1;
         if (m >= (64'd1 << 31)) begin
            m  = m >> 1;
            fr = fr | 1;
         end
      end
      return (longint'(ex) << 20) | fr;
   endfunction

   function automatic logic [7:0] sat_byte(input longint v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
   endfunction

   function automatic longint unsigned exp_fix(input longint unsigned y);
      longint unsigned acc;
      longint unsigned term;
      acc  = 64'd1 << 30;
      term = 64'd1 << 30;
      for (int k = 1; k <= 13; k++) begin
         term = ((term * y) >> 30) / k;
         acc  = acc + term;
      end
      return acc & 64'hffff_ffff;
   endfunction

   function automatic logic [7:0] transform_channel(input logic [7:0] v, input bit neg,
                                                    input longint unsigned gmag);
      longint unsigned r, lnq, t, f, y, mag;
      int unsigned     n, s;
      if (cur_mode == MODE_LOG) begin
         lnq = (log2_fix(32'(v) + 32'd1) * LN2 + (64'd1 << 31)) >> 32;
         r   = (gmag * lnq + (64'd1 << 27)) >> 28;
         return sat_byte(neg ? -longint'(r) : longint'(r));
      end
      if (cur_mode == MODE_POWER) begin
         if (v == 0) begin
            if (cur_gamma != 0) return 8'd0;
            t = 0;
         end else begin
            t = log2_fix(32'(v)) * cur_gamma;
         end
         n = 32'(t >> 28);
         if (n >= 16) return (!neg && gmag != 0) ? 8'd255 : 8'd0;
         f   = t & ((64'd1 << 28) - 1);
         y   = (f * LN2) >> 30;
         mag = (gmag * exp_fix(y)) << n;
         s   = 38 - n;
         r   = (mag + (64'd1 << (s - 1))) >> s;
         return sat_byte(neg ? -longint'(r) : longint'(r));
      end
      // linear, and the unused mode code falls back to linear
      r = (gmag * v + 128) >> 8;
      return sat_byte(neg ? 255 - longint'(r) : longint'(r));
   endfunction

   function automatic rsp_type transform_pixel(input req_type p);
      bit              neg;
      longint unsigned gmag;
      rsp_type         o;
      neg  = cur_gain[15];
      gmag = neg ? (64'h10000 - cur_gain) : cur_gain;
      o.red_out   = transform_channel(p.red_in, neg, gmag);
      o.green_out = transform_channel(p.green_in, neg, gmag);
      o.blue_out  = transform_channel(p.blue_in, neg, gmag);
      return o;
   endfunction

   // ------------------------------------------------------------------
   // driving tasks
   // ------------------------------------------------------------------
   // write enable stays up between back to back writes, set_config drops it
   task automatic write_reg(input csr_index_type idx, input logic [15:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      case (idx)
         CSR_MODE:  cur_mode = val[1:0];
         CSR_GAIN:  cur_gain = val;
         CSR_GAMMA: cur_gamma = val[11:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [1:0] m, input logic [15:0] g, input logic [11:0] e);
      write_reg(CSR_MODE, {14'd0, m});
      write_reg(CSR_GAIN, g);
      write_reg(CSR_GAMMA, {4'd0, e});
      csr_write_en <= 1'b0;
   endtask

   // known expectation (used) or predictor (has_exp = 0)
   task automatic send_pixel(input req_type p, input bit has_exp, input rsp_type exp_px,
                             input bit allow_gap);
      int gap;
      gap = allow_gap ? ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12)) : 0;
      // valid drops only when a gap follows, otherwise it stays up for the next word
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      pending_pixels.push_back(has_exp ? exp_px : transform_pixel(p));
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
   endtask

   // wait for the pipe to drain before touching registers
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (PIPE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // result side: random stall, compare against oldest expectation
   // ------------------------------------------------------------------
   int stall_left = 0;
   bit stall_phase_on = 1;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected pixel word %h", rsp_data);
            end else begin
               rsp_type want;
               want = pending_pixels.pop_front();
               pixels_checked++;
               if (want.red_out !== rsp_data.red_out || want.green_out !== rsp_data.green_out
                   || want.blue_out !== rsp_data.blue_out) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                              want.red_out, want.green_out, want.blue_out,
                              rsp_data.red_out, rsp_data.green_out, rsp_data.blue_out);
               end
            end
         end
         // stall length drawn per word, with stall-free stretches
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else if (stall_phase_on && rsp_valid && !rsp_stall) begin
            stall_left <= $urandom_range(0, 12);
            rsp_stall  <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
         if ($urandom_range(0, 199) == 0) stall_phase_on <= ~stall_phase_on;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // directed table
   // ------------------------------------------------------------------
   typedef struct {
      logic [1:0]  mode;
      logic [15:0] gain;
      logic [11:0] gamma;
      req_type     px;
      bit          known;
      rsp_type     want;
   } vector_type;

   vector_type directed_vectors[] = '{
      // reset registers: identity linear
      '{MODE_LINEAR, 16'h0100, 12'h100, '{8'd0, 8'd255, 8'd128}, 1, '{8'd0, 8'd255, 8'd128}},
      // negative unit gain gives 255 - v
      '{MODE_LINEAR, 16'hff00, 12'h100, '{8'd0, 8'd255, 8'd100}, 1, '{8'd255, 8'd0, 8'd155}},
      // largest gain saturates, most negative gain floors
      '{MODE_LINEAR, 16'h7fff, 12'h100, '{8'd0, 8'd1, 8'd255}, 1, '{8'd0, 8'd128, 8'd255}},
      '{MODE_LINEAR, 16'h8000, 12'h100, '{8'd0, 8'd1, 8'd255}, 1, '{8'd255, 8'd127, 8'd0}},
      '{MODE_LINEAR, 16'h0000, 12'h100, '{8'd7, 8'd1, 8'd255}, 1, '{8'd0, 8'd0, 8'd0}},
      // rounding half away from zero
      '{MODE_LINEAR, 16'h0080, 12'h100, '{8'd1, 8'd3, 8'd255}, 0, '0},
      // mode three behaves as linear
      '{2'd3, 16'h0100, 12'h100, '{8'd9, 8'd200, 8'd255}, 1, '{8'd9, 8'd200, 8'd255}},
      // log: ln(1) is zero
      '{MODE_LOG, 16'h2e00, 12'h100, '{8'd0, 8'd255, 8'd1}, 0, '0},
      '{MODE_LOG, 16'h7fff, 12'h100, '{8'd0, 8'd255, 8'd1}, 0, '0},
      '{MODE_LOG, 16'hc000, 12'h100, '{8'd0, 8'd255, 8'd1}, 1, '{8'd0, 8'd0, 8'd0}},
      // power: zero to the zero is one
      '{MODE_POWER, 16'h0100, 12'h000, '{8'd0, 8'd255, 8'd17}, 1, '{8'd1, 8'd1, 8'd1}},
      '{MODE_POWER, 16'h0100, 12'h100, '{8'd0, 8'd255, 8'd17}, 0, '0},
      '{MODE_POWER, 16'h0100, 12'h080, '{8'd0, 8'd255, 8'd16}, 0, '0},
      // huge power overflows the exponent
      '{MODE_POWER, 16'h0001, 12'hfff, '{8'd0, 8'd255, 8'd2}, 1, '{8'd0, 8'd255, 8'd255}},
      '{MODE_POWER, 16'hffff, 12'hfff, '{8'd0, 8'd255, 8'd2}, 1, '{8'd0, 8'd0, 8'd0}},
      '{MODE_POWER, 16'h0000, 12'hfff, '{8'd0, 8'd255, 8'd2}, 1, '{8'd0, 8'd0, 8'd0}},
      '{MODE_POWER, 16'h7fff, 12'h001, '{8'd1, 8'd254, 8'd128}, 0, '0},
      '{MODE_POWER, 16'h8000, 12'h200, '{8'd1, 8'd254, 8'd128}, 0, '0}
   };

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      int          phase_items;
      logic [1:0]  m;
      logic [15:0] g;
      logic [11:0] e;
      req_type     px;
      cur_mode  = MODE_LINEAR;
      cur_gain  = 16'h0100;
      cur_gamma = 12'h100;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first row runs on reset registers untouched
      foreach (directed_vectors[i]) begin
         if (i != 0) begin
            drain();
            set_config(directed_vectors[i].mode, directed_vectors[i].gain,
                       directed_vectors[i].gamma);
         end
         send_pixel(directed_vectors[i].px, directed_vectors[i].known,
                    directed_vectors[i].want, 1);
      end

      // random phases, each with a fresh setting
      while (pixels_sent < 720) begin
         drain();
         m = 2'($urandom_range(0, 3));
         case ($urandom_range(0, 5))
            0: g = 16'h7fff;
            1: g = 16'h8000;
            2: g = 16'($urandom_range(0, 16'h0400));
            3: g = 16'(-$urandom_range(0, 16'h0400));
            default: g = 16'($urandom);
         endcase
         case ($urandom_range(0, 4))
            0: e = 12'h000;
            1: e = 12'hfff;
            default: e = 12'($urandom_range(0, 12'h400));
         endcase
         set_config(m, g, e);
         phase_items = $urandom_range(10, 60);
         for (int k = 0; k < phase_items; k++) begin
            px = 24'($urandom);
            send_pixel(px, 0, '0, 1);
         end
         // a burst with no gaps
         for (int k = 0; k < 10; k++) begin
            px = 24'($urandom);
            send_pixel(px, 0, '0, 0);
         end
      end

      drain();
      $display("sent %0d pixel words, checked %0d results across directed and random settings",
               pixels_sent, pixels_checked);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/pctx_pkg.sv
sv/pctx_lane.sv
sv/pixel_contrast_point_transform_core.sv
tb/sv/tb.sv
